### hw/rtl/assert_macros.svh
// assertion macros shared by the history interpolator modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on clk_i, off while rst_ni is low
`define AHI_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, clocked on clk_i, off while rst_ni is low
`define AHI_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### hw/rtl/ahi_pkg.sv
// types and constants of the acceleration history interpolator
package ahi_pkg;

  localparam int unsigned DIV_W = 48;
  localparam int unsigned DVS_W = 33;
  localparam int unsigned PER_W = 20;
  localparam logic [PER_W-1:0] PERIOD_RST = 20'd8000;

  typedef enum logic [1:0] {
    OP_STORE = 2'd0,
    OP_READ  = 2'd1,
    OP_RATE  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_OFS,
    ST_DIVW,
    ST_RDA,
    ST_RDB,
    ST_RDC,
    ST_MUL,
    ST_ADD,
    ST_RATE,
    ST_RWAIT,
    ST_OUT
  } state_e;

  typedef logic [2:0][31:0] vec3_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

### hw/rtl/accel_history_interpolator.sv
// top level: running sums, ring history, offset lookup, interpolation and rate
//
//  channel  dir  handshake                  payload
//  in       in   in_valid_i / in_ready_o    operation, sample_x/y/z, time_a, time_b
//  out      out  out_valid_o / out_ready_i  out_x/y/z, status
//  cfg      in   cfg_valid_i / cfg_ready_o  sample_period_us
//
// a store completes as it is accepted; a read and a rate wait on the shared divider
// (at most one offset division per lookup, three rate divisions) and on two history
// reads per lookup. a zero-span rate goes from accept straight to the output state.
// one item at a time; the output register holds a result while the next item runs.
// reset gives a zero history through a fill count, no clearing pass.
`include "assert_macros.svh"
module accel_history_interpolator #(
  parameter int unsigned HISTORY_DEPTH = 2048
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          operation_i,
  input  logic signed [15:0]  sample_x_i,
  input  logic signed [15:0]  sample_y_i,
  input  logic signed [15:0]  sample_z_i,
  input  logic [31:0]         time_a_i,
  input  logic [31:0]         time_b_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [31:0]  out_x_o,
  output logic signed [31:0]  out_y_o,
  output logic signed [31:0]  out_z_o,
  output logic                status_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [19:0]         cfg_sample_period_us_i
);

  localparam int unsigned AW = $clog2(HISTORY_DEPTH);
  localparam int unsigned FW = $clog2(HISTORY_DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(HISTORY_DEPTH - 1);
  localparam logic [FW-1:0] FILL_MAX = FW'(HISTORY_DEPTH);
  localparam logic [AW+1:0] DEP_X    = (AW+2)'(HISTORY_DEPTH);

  ahi_pkg::state_e state_q, state_d;
  ahi_pkg::op_e    op_q, op_d;
  logic [31:0]     ta_q, ta_d, tb_q, tb_d;
  logic            sel_q, sel_d;
  logic [1:0]      axis_q, axis_d;
  logic [15:0]     f_q, f_d;
  logic [AW-1:0]   mi_q, mi_d, ni_q, ni_d;
  logic            rvld_q, rvld_d;
  logic            neg_q, neg_d;
  ahi_pkg::vec3_t  a_q, a_d, b_q, b_d, va_q, va_d, vb_q, vb_d, res_q, res_d;
  logic            res_st_q, res_st_d;
  logic signed [48:0] prod_q, prod_d;

  logic [31:0]     run_x_q, run_x_d, run_y_q, run_y_d, run_z_q, run_z_d;
  logic [AW-1:0]   wp_q, wp_d;
  logic [FW-1:0]   fill_q, fill_d;
  logic [31:0]     last_q, last_d;
  logic [19:0]     period_q, period_d;

  logic            outv_q, outv_d;
  ahi_pkg::vec3_t  out_q, out_d;
  logic            outst_q, outst_d;

  ahi_pkg::div_req_t div_req;
  ahi_pkg::div_rsp_t div_rsp;
  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_ra;
  ahi_pkg::vec3_t  mem_wd, mem_rd, mem_rd_m;
  logic            in_acc;

  assign in_ready_o  = (state_q == ahi_pkg::ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign mem_rd_m    = rvld_q ? mem_rd : '0;

  always_comb begin
    logic [31:0]   t_cur;
    logic [32:0]   dt;
    logic [19:0]   per_eff;
    logic [AW-1:0] newest;
    logic [31:0]   m;
    logic [AW+1:0] mi_w;
    logic [31:0]   dif;
    logic [31:0]   vnew;
    logic [47:0]   num, num_mag;
    logic [32:0]   span, span_mag;
    logic [47:0]   q;
    logic [31:0]   rq;

    state_d  = state_q;
    op_d     = op_q;
    ta_d     = ta_q;
    tb_d     = tb_q;
    sel_d    = sel_q;
    axis_d   = axis_q;
    f_d      = f_q;
    mi_d     = mi_q;
    ni_d     = ni_q;
    rvld_d   = rvld_q;
    neg_d    = neg_q;
    a_d      = a_q;
    b_d      = b_q;
    va_d     = va_q;
    vb_d     = vb_q;
    res_d    = res_q;
    res_st_d = res_st_q;
    prod_d   = prod_q;
    run_x_d  = run_x_q;
    run_y_d  = run_y_q;
    run_z_d  = run_z_q;
    wp_d     = wp_q;
    fill_d   = fill_q;
    last_d   = last_q;
    period_d = period_q;
    outv_d   = outv_q;
    out_d    = out_q;
    outst_d  = outst_q;
    div_req  = '0;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    mem_ra   = mi_q;
    mem_wd   = '0;

    t_cur    = sel_q ? tb_q : ta_q;
    dt       = {1'b0, last_q} - {1'b0, t_cur};
    per_eff  = (period_q == '0) ? 20'd1 : period_q;
    newest   = (wp_q == '0) ? LAST_IDX : wp_q - AW'(1);
    m        = div_rsp.quotient[47:16];
    mi_w     = {2'b0, wp_q} - (AW+2)'(1) - {2'b0, m[AW-1:0]};
    if (mi_w[AW+1]) begin
      mi_w = mi_w + DEP_X;
    end
    dif      = b_q[axis_q] - a_q[axis_q];
    vnew     = a_q[axis_q] + prod_q[47:16];
    num      = {va_q[axis_q] - vb_q[axis_q], 16'h0};
    num_mag  = num[47] ? 48'd0 - num : num;
    span     = {1'b0, ta_q} - {1'b0, tb_q};
    span_mag = span[32] ? 33'd0 - span : span;
    q        = div_rsp.quotient;
    rq       = '0;

    if (cfg_valid_i) begin
      period_d = cfg_sample_period_us_i;
    end
    if (outv_q && out_ready_i) begin
      outv_d = 1'b0;
    end

    case (state_q)
      ahi_pkg::ST_IDLE: begin
        if (in_acc) begin
          op_d  = ahi_pkg::op_e'(operation_i);
          ta_d  = time_a_i;
          tb_d  = time_b_i;
          sel_d = 1'b0;
          case (ahi_pkg::op_e'(operation_i))
            ahi_pkg::OP_STORE: begin
              run_x_d   = run_x_q + {{16{sample_x_i[15]}}, sample_x_i};
              run_y_d   = run_y_q + {{16{sample_y_i[15]}}, sample_y_i};
              run_z_d   = run_z_q + {{16{sample_z_i[15]}}, sample_z_i};
              mem_we    = 1'b1;
              mem_wd[0] = run_x_d;
              mem_wd[1] = run_y_d;
              mem_wd[2] = run_z_d;
              wp_d      = (wp_q == LAST_IDX) ? '0 : wp_q + AW'(1);
              fill_d    = (fill_q == FILL_MAX) ? fill_q : fill_q + FW'(1);
              last_d    = time_a_i;
            end
            ahi_pkg::OP_READ: begin
              state_d = ahi_pkg::ST_OFS;
            end
            ahi_pkg::OP_RATE: begin
              if (time_a_i == time_b_i) begin
                res_d    = '0;
                res_st_d = 1'b1;
                state_d  = ahi_pkg::ST_OUT;
              end else begin
                state_d = ahi_pkg::ST_OFS;
              end
            end
            default: ;
          endcase
        end
      end
      ahi_pkg::ST_OFS: begin
        if (dt[32] || dt == '0) begin
          // at or after the last stamp: newest entry as is
          mi_d    = newest;
          ni_d    = newest;
          f_d     = '0;
          state_d = ahi_pkg::ST_RDA;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = {dt[31:0], 16'h0};
          div_req.divisor  = {13'b0, per_eff};
          state_d          = ahi_pkg::ST_DIVW;
        end
      end
      ahi_pkg::ST_DIVW: begin
        if (div_rsp.done) begin
          if (m >= 32'(HISTORY_DEPTH - 1)) begin
            // past the history: oldest slot, no blend
            mi_d = wp_q;
            ni_d = wp_q;
            f_d  = '0;
          end else begin
            mi_d = mi_w[AW-1:0];
            ni_d = (mi_w[AW-1:0] == '0) ? LAST_IDX : mi_w[AW-1:0] - AW'(1);
            f_d  = q[15:0];
          end
          state_d = ahi_pkg::ST_RDA;
        end
      end
      ahi_pkg::ST_RDA: begin
        mem_re  = 1'b1;
        mem_ra  = mi_q;
        rvld_d  = (FW'(mi_q) < fill_q);
        state_d = ahi_pkg::ST_RDB;
      end
      ahi_pkg::ST_RDB: begin
        mem_re  = 1'b1;
        mem_ra  = ni_q;
        rvld_d  = (FW'(ni_q) < fill_q);
        a_d     = mem_rd_m;
        state_d = ahi_pkg::ST_RDC;
      end
      ahi_pkg::ST_RDC: begin
        b_d     = mem_rd_m;
        axis_d  = '0;
        state_d = ahi_pkg::ST_MUL;
      end
      ahi_pkg::ST_MUL: begin
        prod_d  = $signed(dif) * $signed({1'b0, f_q});
        state_d = ahi_pkg::ST_ADD;
      end
      ahi_pkg::ST_ADD: begin
        if (sel_q) begin
          vb_d[axis_q] = vnew;
        end else begin
          va_d[axis_q] = vnew;
        end
        if (axis_q == 2'd2) begin
          if (op_q == ahi_pkg::OP_READ) begin
            res_d    = va_d;
            res_st_d = 1'b0;
            state_d  = ahi_pkg::ST_OUT;
          end else if (!sel_q) begin
            sel_d   = 1'b1;
            state_d = ahi_pkg::ST_OFS;
          end else begin
            axis_d  = '0;
            state_d = ahi_pkg::ST_RATE;
          end
        end else begin
          axis_d  = axis_q + 2'd1;
          state_d = ahi_pkg::ST_MUL;
        end
      end
      ahi_pkg::ST_RATE: begin
        neg_d            = num[47] ^ span[32];
        div_req.start    = 1'b1;
        div_req.dividend = num_mag;
        div_req.divisor  = span_mag;
        state_d          = ahi_pkg::ST_RWAIT;
      end
      ahi_pkg::ST_RWAIT: begin
        if (div_rsp.done) begin
          // truncate toward zero, saturate to 32 bits signed
          if (neg_q) begin
            rq = (q > 48'h0000_8000_0000) ? 32'h8000_0000 : 32'd0 - q[31:0];
          end else begin
            rq = (q > 48'h0000_7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
          end
          res_d[axis_q] = rq;
          if (axis_q == 2'd2) begin
            res_st_d = 1'b0;
            state_d  = ahi_pkg::ST_OUT;
          end else begin
            axis_d  = axis_q + 2'd1;
            state_d = ahi_pkg::ST_RATE;
          end
        end
      end
      ahi_pkg::ST_OUT: begin
        if (!outv_q || out_ready_i) begin
          outv_d  = 1'b1;
          out_d   = res_q;
          outst_d = res_st_q;
          state_d = ahi_pkg::ST_IDLE;
        end
      end
      default: state_d = ahi_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ahi_pkg::ST_IDLE;
      sel_q    <= 1'b0;
      axis_q   <= '0;
      rvld_q   <= 1'b0;
      run_x_q  <= '0;
      run_y_q  <= '0;
      run_z_q  <= '0;
      wp_q     <= '0;
      fill_q   <= '0;
      last_q   <= '0;
      period_q <= ahi_pkg::PERIOD_RST;
      outv_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      sel_q    <= sel_d;
      axis_q   <= axis_d;
      rvld_q   <= rvld_d;
      run_x_q  <= run_x_d;
      run_y_q  <= run_y_d;
      run_z_q  <= run_z_d;
      wp_q     <= wp_d;
      fill_q   <= fill_d;
      last_q   <= last_d;
      period_q <= period_d;
      outv_q   <= outv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    ta_q     <= ta_d;
    tb_q     <= tb_d;
    f_q      <= f_d;
    mi_q     <= mi_d;
    ni_q     <= ni_d;
    neg_q    <= neg_d;
    a_q      <= a_d;
    b_q      <= b_d;
    va_q     <= va_d;
    vb_q     <= vb_d;
    res_q    <= res_d;
    res_st_q <= res_st_d;
    prod_q   <= prod_d;
    out_q    <= out_d;
    outst_q  <= outst_d;
  end

  ahi_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  ahi_hist_mem #(
    .DEPTH (HISTORY_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (mem_we),
    .wr_addr_i (wp_q),
    .wr_data_i (mem_wd),
    .rd_en_i   (mem_re),
    .rd_addr_i (mem_ra),
    .rd_data_o (mem_rd)
  );

  assign out_valid_o = outv_q;
  assign out_x_o     = $signed(out_q[0]);
  assign out_y_o     = $signed(out_q[1]);
  assign out_z_o     = $signed(out_q[2]);
  assign status_o    = outst_q;

  `AHI_ASSERT_IMP(a_fill_bound, 1'b1, fill_q <= FILL_MAX)
  `AHI_ASSERT_NXT(a_wp_step, in_acc && operation_i == ahi_pkg::OP_STORE, wp_q == (($past(wp_q) == LAST_IDX) ? '0 : $past(wp_q) + AW'(1)))
  `AHI_ASSERT_IMP(a_zero_span, outv_q && outst_q, out_q == '0)

endmodule

### hw/rtl/ahi_div.sv
// iterative restoring divider, one quotient bit per cycle
`include "assert_macros.svh"
module ahi_div (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ahi_pkg::div_req_t req_i,
  output ahi_pkg::div_rsp_t rsp_o
);

  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [5:0]                  cnt_q, cnt_d;
  logic [ahi_pkg::DVS_W-1:0]   rem_q, rem_d;
  logic [ahi_pkg::DIV_W-1:0]   quo_q, quo_d;
  logic [ahi_pkg::DVS_W-1:0]   dvs_q, dvs_d;
  logic [ahi_pkg::DVS_W:0]     trial;
  logic                        qbit;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    trial  = {rem_q, quo_q[ahi_pkg::DIV_W-1]};
    qbit   = (trial >= {1'b0, dvs_q});
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      if (qbit) begin
        trial = trial - {1'b0, dvs_q};
      end
      rem_d = trial[ahi_pkg::DVS_W-1:0];
      quo_d = {quo_q[ahi_pkg::DIV_W-2:0], qbit};
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'(ahi_pkg::DIV_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

  `AHI_ASSERT_IMP(a_div_start_idle, req_i.start, !busy_q)

endmodule

### hw/rtl/ahi_hist_mem.sv
// ring history memory, x y z sums side by side, registered read
module ahi_hist_mem #(
  parameter int unsigned DEPTH = 2048,
  parameter int unsigned AW    = 11
) (
  input  logic                  clk_i,
  input  logic                  wr_en_i,
  input  logic [AW-1:0]         wr_addr_i,
  input  ahi_pkg::vec3_t        wr_data_i,
  input  logic                  rd_en_i,
  input  logic [AW-1:0]         rd_addr_i,
  output ahi_pkg::vec3_t        rd_data_o
);

  ahi_pkg::vec3_t mem [DEPTH];
  ahi_pkg::vec3_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

### dv/tb.sv
// testbench for the acceleration history interpolator: random and directed items
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH = 2048;
  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned DRAIN_CYCLES = 400;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        status;
  } result_t;

  // model of the history block and the queue of results it should produce
  class interp_scoreboard;
    logic [19:0] period;
    logic [31:0] sum_x, sum_y, sum_z, stamp;
    logic [31:0] hist_x [DEPTH];
    logic [31:0] hist_y [DEPTH];
    logic [31:0] hist_z [DEPTH];
    int unsigned wr_pos;
    result_t pending[$];
    int unsigned errors;

    function void clear();
      period = ahi_pkg::PERIOD_RST;
      sum_x = 0; sum_y = 0; sum_z = 0; stamp = 0; wr_pos = 0;
      for (int i = 0; i < DEPTH; i++) begin
        hist_x[i] = 0; hist_y[i] = 0; hist_z[i] = 0;
      end
      pending.delete();
      errors = 0;
    endfunction

    function logic [31:0] blend(logic [31:0] a, logic [31:0] b, longint f);
      longint d, p, q;
      d = longint'($signed(b - a));
      p = d * f;
      q = (p >= 0) ? p / 65536 : -((-p + 65535) / 65536);
      return a + q[31:0];
    endfunction

    function void lookup(logic [31:0] t, output logic [31:0] v[3]);
      longint per, dt, cnt, rem, f;
      int unsigned mi, ni;
      per = (period == 0) ? 1 : longint'(period);
      dt = longint'(stamp) - longint'(t);
      if (dt <= 0) begin
        mi = (wr_pos + DEPTH - 1) % DEPTH;
        v[0] = hist_x[mi]; v[1] = hist_y[mi]; v[2] = hist_z[mi];
        return;
      end
      cnt = dt / per;
      rem = dt % per;
      if (cnt >= DEPTH - 1) begin
        v[0] = hist_x[wr_pos]; v[1] = hist_y[wr_pos]; v[2] = hist_z[wr_pos];
        return;
      end
      f = (rem << 16) / per;
      mi = (wr_pos + DEPTH - 1 - int'(cnt)) % DEPTH;
      ni = (mi + DEPTH - 1) % DEPTH;
      v[0] = blend(hist_x[mi], hist_x[ni], f);
      v[1] = blend(hist_y[mi], hist_y[ni], f);
      v[2] = blend(hist_z[mi], hist_z[ni], f);
    endfunction

    function logic [31:0] slope(logic [31:0] hi, logic [31:0] lo, longint span);
      longint q;
      q = (longint'($signed(hi - lo)) * 65536) / span;
      if (q > 64'sd2147483647) q = 64'sd2147483647;
      if (q < -64'sd2147483648) q = -64'sd2147483648;
      return q[31:0];
    endfunction

    function void note_item(logic [1:0] op, logic [15:0] sx, logic [15:0] sy,
                            logic [15:0] sz, logic [31:0] ta, logic [31:0] tb_v);
      logic [31:0] va[3], vb[3];
      result_t r;
      longint span;
      r = '0;
      case (ahi_pkg::op_e'(op))
        ahi_pkg::OP_STORE: begin
          sum_x += {{16{sx[15]}}, sx};
          sum_y += {{16{sy[15]}}, sy};
          sum_z += {{16{sz[15]}}, sz};
          hist_x[wr_pos] = sum_x; hist_y[wr_pos] = sum_y; hist_z[wr_pos] = sum_z;
          wr_pos = (wr_pos + 1) % DEPTH;
          stamp = ta;
        end
        ahi_pkg::OP_READ: begin
          lookup(ta, va);
          r.x = va[0]; r.y = va[1]; r.z = va[2];
          pending.push_back(r);
        end
        ahi_pkg::OP_RATE: begin
          span = longint'(ta) - longint'(tb_v);
          if (span == 0) begin
            r.status = 1'b1;
          end else begin
            lookup(ta, va);
            lookup(tb_v, vb);
            r.x = slope(va[0], vb[0], span);
            r.y = slope(va[1], vb[1], span);
            r.z = slope(va[2], vb[2], span);
          end
          pending.push_back(r);
        end
        default: ;
      endcase
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result x=%h y=%h z=%h status=%b", $time,
                 got.x, got.y, got.z, got.status);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.x !== want.x) begin
        $display("%0t: out_x expected %h actual %h", $time, want.x, got.x); errors++;
      end
      if (got.y !== want.y) begin
        $display("%0t: out_y expected %h actual %h", $time, want.y, got.y); errors++;
      end
      if (got.z !== want.z) begin
        $display("%0t: out_z expected %h actual %h", $time, want.z, got.z); errors++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status expected %b actual %b", $time, want.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] operation_i = '0;
  logic signed [15:0] sample_x_i = '0, sample_y_i = '0, sample_z_i = '0;
  logic [31:0] time_a_i = '0, time_b_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [31:0] out_x_o, out_y_o, out_z_o;
  logic status_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [19:0] cfg_sample_period_us_i = '0;

  accel_history_interpolator #(.HISTORY_DEPTH(DEPTH)) uut (.*);

  interp_scoreboard board = new();
  int unsigned send_idle_pct = 7;
  int unsigned recv_idle_pct = 49;
  int unsigned quiet_cycles = 0;
  logic [31:0] clock_us = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // receiver: random back-pressure and checking of every accepted result
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i)
        board.check_result('{out_x_o, out_y_o, out_z_o, status_o});
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog on stretches with no handshake on the in, out or cfg channel
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // valid stays high after an accepted item until the next idle cycle or drain
  task automatic send_item(logic [1:0] op, logic [15:0] sx, logic [15:0] sy,
                           logic [15:0] sz, logic [31:0] ta, logic [31:0] tb_v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= op;
    sample_x_i <= sx; sample_y_i <= sy; sample_z_i <= sz;
    time_a_i <= ta; time_b_i <= tb_v;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_item(op, sx, sy, sz, ta, tb_v);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_period(logic [19:0] p);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_sample_period_us_i <= p;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.period = p;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic store_next(logic [31:0] step);
    clock_us += step;
    send_item(ahi_pkg::OP_STORE, 16'($urandom), 16'($urandom), 16'($urandom),
              clock_us, '0);
  endtask

  // times around the recorded span, with some far outliers
  function automatic logic [31:0] pick_time();
    longint span;
    span = longint'(board.period) * ($urandom_range(3) == 0 ? DEPTH + 8 : 40);
    case ($urandom_range(9))
      0: return $urandom;
      1: return board.stamp + $urandom_range(50);
      default: return board.stamp - 32'($urandom_range(0, int'(span)));
    endcase
  endfunction

  task automatic random_phase(int unsigned count);
    int unsigned k;
    logic [31:0] ta, tbv;
    for (k = 0; k < count; k++) begin
      case ($urandom_range(19))
        0, 1, 2, 3, 4, 5, 6, 7:
          store_next(board.period + 32'($urandom_range(0, 3)) - 1);
        8, 9, 10, 11, 12:
          send_item(ahi_pkg::OP_READ, 16'($urandom), 16'($urandom), 16'($urandom),
                    pick_time(), $urandom);
        13, 14, 15, 16, 17: begin
          ta = pick_time();
          tbv = ($urandom_range(7) == 0) ? ta : pick_time();
          send_item(ahi_pkg::OP_RATE, 16'($urandom), 16'($urandom), 16'($urandom),
                    ta, tbv);
        end
        18: send_item(ahi_pkg::OP_NONE, 16'($urandom), 16'($urandom), 16'($urandom),
                      $urandom, $urandom);
        default: store_next($urandom_range(0, 3 * int'(board.period)));
      endcase
    end
  endtask

  initial begin
    board.clear();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty history, extremes of samples and times, zero span, ignored op
    send_item(ahi_pkg::OP_READ, '0, '0, '0, 32'd0, 32'd0);
    send_item(ahi_pkg::OP_RATE, '0, '0, '0, 32'hFFFF_FFFF, 32'd0);
    send_item(ahi_pkg::OP_STORE, 16'h7FFF, 16'h8000, 16'hFFFF, 32'd1000, '0);
    send_item(ahi_pkg::OP_STORE, 16'h8000, 16'h7FFF, 16'h0001, 32'd9000, '0);
    send_item(ahi_pkg::OP_STORE, 16'h7FFF, 16'h7FFF, 16'h8000, 32'd17000, '0);
    send_item(ahi_pkg::OP_READ, '0, '0, '0, 32'd17000, '0);
    send_item(ahi_pkg::OP_READ, '0, '0, '0, 32'd20000, '0);
    send_item(ahi_pkg::OP_READ, '0, '0, '0, 32'd12345, '0);
    send_item(ahi_pkg::OP_READ, '0, '0, '0, 32'd0, '0);
    send_item(ahi_pkg::OP_READ, '0, '0, '0, 32'hFFFF_FFFF, '0);
    send_item(ahi_pkg::OP_RATE, '0, '0, '0, 32'd17000, 32'd1000);
    send_item(ahi_pkg::OP_RATE, '0, '0, '0, 32'd1000, 32'd17000);
    send_item(ahi_pkg::OP_RATE, '0, '0, '0, 32'd5000, 32'd5000);
    send_item(ahi_pkg::OP_RATE, '0, '0, '0, 32'd9001, 32'd9000);
    send_item(ahi_pkg::OP_RATE, '0, '0, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
    send_item(ahi_pkg::OP_NONE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF,
              32'hFFFF_FFFF);
    clock_us = 17000;

    write_period(20'd1);
    repeat (30) store_next(32'd1);
    send_item(ahi_pkg::OP_READ, '0, '0, '0, clock_us - 32'd5, '0);
    write_period(20'd0);
    send_item(ahi_pkg::OP_READ, '0, '0, '0, clock_us - 32'd3, '0);
    send_item(ahi_pkg::OP_RATE, '0, '0, '0, clock_us, clock_us - 32'd7);
    write_period(20'hFFFFF);
    store_next(32'h000F_FFFF);
    store_next(32'h000F_FFFF);
    send_item(ahi_pkg::OP_READ, '0, '0, '0, clock_us - 32'd500000, '0);

    // random phases over several periods and idling patterns
    write_period(20'd8000);
    random_phase(250);
    write_period(20'd3);
    random_phase(250);
    send_idle_pct = 49;
    recv_idle_pct = 7;
    write_period(20'd1000);
    random_phase(250);
    write_period(20'($urandom_range(1, 1000000)));
    random_phase(250);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_period(20'd8000);
    // a run of stores at the nominal period
    repeat (200) store_next(32'd8000);
    random_phase(250);

    drain();
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
